// ===== design/stk_pkg.sv =====
package stk_pkg;

  localparam int STACK_DEPTH_DEF = 4;
  localparam int REG_COUNT_DEF   = 4;
  localparam int MUL_STEPS       = 4;
  localparam int DIV_STEPS       = 64;

  typedef logic [6:0]  opcode_t;
  typedef logic [63:0] word_t;
  typedef logic [1:0]  err_t;

  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_DIV0 = 2'd1;
  localparam err_t ERR_NIMP = 2'd2;
  localparam err_t ERR_BAD  = 2'd3;

  localparam opcode_t OP_NOP     = 7'd0;
  localparam opcode_t OP_ADD     = 7'd1;
  localparam opcode_t OP_SUB     = 7'd2;
  localparam opcode_t OP_RSUB    = 7'd3;
  localparam opcode_t OP_NEG     = 7'd4;
  localparam opcode_t OP_ADDW    = 7'd5;
  localparam opcode_t OP_SUBW    = 7'd6;
  localparam opcode_t OP_RSUBW   = 7'd7;
  localparam opcode_t OP_MUL     = 7'd8;
  localparam opcode_t OP_MULH    = 7'd9;
  localparam opcode_t OP_MULHU   = 7'd11;
  localparam opcode_t OP_DIV     = 7'd12;
  localparam opcode_t OP_REM     = 7'd13;
  localparam opcode_t OP_DIVU    = 7'd14;
  localparam opcode_t OP_REMU    = 7'd15;
  localparam opcode_t OP_MULW    = 7'd16;
  localparam opcode_t OP_DIVW    = 7'd17;
  localparam opcode_t OP_REMW    = 7'd18;
  localparam opcode_t OP_REMUW   = 7'd19;
  localparam opcode_t OP_ADD_A   = 7'd20;
  localparam opcode_t OP_ADDW_A  = 7'd24;
  localparam opcode_t OP_SLL     = 7'd28;
  localparam opcode_t OP_SRL     = 7'd29;
  localparam opcode_t OP_SRA     = 7'd30;
  localparam opcode_t OP_SLLW    = 7'd31;
  localparam opcode_t OP_SRLW    = 7'd32;
  localparam opcode_t OP_SRAW    = 7'd33;
  localparam opcode_t OP_AND     = 7'd34;
  localparam opcode_t OP_OR      = 7'd35;
  localparam opcode_t OP_XOR     = 7'd36;
  localparam opcode_t OP_NOT     = 7'd37;
  localparam opcode_t OP_SLT     = 7'd38;
  localparam opcode_t OP_SLTU    = 7'd39;
  localparam opcode_t OP_SEQ     = 7'd40;
  localparam opcode_t OP_SLT_A   = 7'd41;
  localparam opcode_t OP_SLTU_A  = 7'd45;
  localparam opcode_t OP_SEQ_A   = 7'd49;
  localparam opcode_t OP_EXTB    = 7'd53;
  localparam opcode_t OP_EXTUB   = 7'd54;
  localparam opcode_t OP_EXTH    = 7'd55;
  localparam opcode_t OP_EXTUH   = 7'd56;
  localparam opcode_t OP_EXTW    = 7'd57;
  localparam opcode_t OP_EXTUW   = 7'd58;
  localparam opcode_t OP_RD_S    = 7'd59;
  localparam opcode_t OP_RD_R    = 7'd63;
  localparam opcode_t OP_WP_R    = 7'd67;
  localparam opcode_t OP_WR_R    = 7'd71;
  localparam opcode_t OP_RD_A    = 7'd75;
  localparam opcode_t OP_SELZ_A  = 7'd83;
  localparam opcode_t OP_SELNZ_A = 7'd87;
  localparam opcode_t OP_CONB    = 7'd91;
  localparam opcode_t OP_CONH    = 7'd99;
  localparam opcode_t OP_CONW    = 7'd107;
  localparam opcode_t OP_COND    = 7'd115;
  localparam opcode_t OP_RSVD    = 7'd123;

  typedef struct packed {
    logic load;
    logic op_start;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic needs_mul;
    logic needs_div;
  } sts_t;

  function automatic word_t sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // number of stack operands popped
  function automatic logic [1:0] op_na(input opcode_t o);
    logic [1:0] n;
    n = 2'd0;
    if ((o >= OP_ADD && o <= OP_RSUB) || (o >= OP_ADDW && o <= OP_REMUW) ||
        (o >= OP_SLL && o <= OP_XOR) || (o >= OP_SLT && o <= OP_SEQ) ||
        (o >= OP_SELZ_A && o < OP_CONB))
      n = 2'd2;
    else if (o == OP_NEG || (o >= OP_ADD_A && o < OP_SLL) || o == OP_NOT ||
             (o >= OP_SLT_A && o <= OP_EXTUW) || (o >= OP_WP_R && o < OP_RD_A))
      n = 2'd1;
    return n;
  endfunction

endpackage

// ===== design/stk_if.sv =====
interface stk_in_if;
  logic                    valid;
  logic                    ready;
  stk_pkg::opcode_t        opcode;
  logic signed [63:0]      remote_value;
  logic [63:0]             const_raw;
  modport source (output valid, opcode, remote_value, const_raw, input ready);
  modport sink (input valid, opcode, remote_value, const_raw, output ready);
endinterface

interface stk_out_if;
  logic                    valid;
  logic                    ready;
  stk_pkg::err_t           err_code;
  logic signed [63:0]      top_value;
  modport source (output valid, err_code, top_value, input ready);
  modport sink (input valid, err_code, top_value, output ready);
endinterface

// ===== design/stk_ctrl.sv =====
module stk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  stk_pkg::sts_t sts,
  output stk_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam int CW = $clog2(stk_pkg::DIV_STEPS);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op_start = 1'b1;
        if (sts.needs_mul) begin
          state_nxt = S_MUL;
          cnt_nxt   = CW'(stk_pkg::MUL_STEPS - 1);
        end else if (sts.needs_div) begin
          state_nxt = S_DIV;
          cnt_nxt   = CW'(stk_pkg::DIV_STEPS - 1);
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_MUL, S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/stk_datapath.sv =====
module stk_datapath #(
  parameter int STACK_DEPTH = stk_pkg::STACK_DEPTH_DEF,
  parameter int REG_COUNT   = stk_pkg::REG_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stk_pkg::cmd_t    cmd,
  output stk_pkg::sts_t    sts,
  input  stk_pkg::opcode_t opcode,
  input  logic [63:0]      remote_value,
  input  logic [63:0]      const_raw,
  output stk_pkg::err_t    err_code,
  output logic [63:0]      top_value
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int RW = $clog2(REG_COUNT);

  stk_pkg::opcode_t op_r;
  logic [63:0] rv_r, cr_r, a0_r, a1_r;
  logic [63:0] rot_r [STACK_DEPTH];   // rot_r[p] is the slot p above the top
  logic [63:0] rot_nxt [STACK_DEPTH];
  logic [63:0] regs_r [REG_COUNT];
  logic [63:0] p_r, acc_r, quo_r, rem_r, ub_r;
  logic [1:0]  mph_r;
  logic        negq_r, negr_r;
  stk_pkg::err_t err_r;
  logic [63:0] top_r;

  // decode-time operand fetch
  logic [1:0]  na;
  logic [63:0] pa0, pa1;
  logic        is_div, div_sg, div_w, div0_c;
  logic [63:0] dx, dy, ua, ub;

  assign na  = stk_pkg::op_na(op_r);
  assign pa1 = (na == 2'd2) ? rot_r[0] : '0;
  assign pa0 = (na == 2'd2) ? rot_r[STACK_DEPTH-1] : ((na == 2'd1) ? rot_r[0] : '0);

  assign is_div = (op_r >= stk_pkg::OP_DIV && op_r <= stk_pkg::OP_REMUW) &&
                  (op_r != stk_pkg::OP_MULW);
  assign div_sg = (op_r == stk_pkg::OP_DIV) || (op_r == stk_pkg::OP_REM) ||
                  (op_r == stk_pkg::OP_DIVW) || (op_r == stk_pkg::OP_REMW);
  assign div_w  = (op_r >= stk_pkg::OP_DIVW);
  assign div0_c = div_w ? (pa1[31:0] == '0) : (pa1 == '0);

  always_comb begin
    dx = pa0;
    dy = pa1;
    if (op_r == stk_pkg::OP_REMUW) begin
      dx = {32'b0, pa0[31:0]};
      dy = {32'b0, pa1[31:0]};
    end else if (div_w) begin
      dx = stk_pkg::sext32(pa0[31:0]);
      dy = stk_pkg::sext32(pa1[31:0]);
    end
    ua = (div_sg && dx[63]) ? (64'd0 - dx) : dx;
    ub = (div_sg && dy[63]) ? (64'd0 - dy) : dy;
  end

  assign sts.needs_mul = (op_r == stk_pkg::OP_MUL) || (op_r == stk_pkg::OP_MULW);
  assign sts.needs_div = is_div && !div0_c;

  // shared 32x32 multiplier, one partial product per step
  logic [31:0] mx, my;
  logic [64:0] trial;
  logic        ge;
  always_comb begin
    case (mph_r)
      2'd0:    begin mx = a0_r[31:0];  my = a1_r[31:0];  end
      2'd1:    begin mx = a0_r[31:0];  my = a1_r[63:32]; end
      default: begin mx = a0_r[63:32]; my = a1_r[31:0];  end
    endcase
    trial = {rem_r, quo_r[63]};
    ge    = trial >= {1'b0, ub_r};
  end

  // commit-time result
  logic        div0, push;
  stk_pkg::err_t err_c;
  logic [63:0] r, q_f, r_f, dres;
  logic [SW-1:0] dsh, sidx;
  logic [RW-1:0] ridx;
  logic        reg_we;
  stk_pkg::opcode_t o;

  always_comb begin
    o      = op_r;
    div0   = is_div && ((div_w && a1_r[31:0] == '0) || (!div_w && a1_r == '0));
    q_f    = negq_r ? (64'd0 - quo_r) : quo_r;
    r_f    = negr_r ? (64'd0 - rem_r) : rem_r;
    dres   = (o == stk_pkg::OP_DIV || o == stk_pkg::OP_DIVU || o == stk_pkg::OP_DIVW) ?
             q_f : r_f;
    if (div_w) dres = stk_pkg::sext32(dres[31:0]);
    sidx   = SW'(o - stk_pkg::OP_RD_S);
    ridx   = RW'(o - stk_pkg::OP_RD_R);
    reg_we = 1'b0;
    r      = '0;
    push   = 1'b0;
    err_c  = stk_pkg::ERR_NONE;
    if (div0) begin
      err_c = stk_pkg::ERR_DIV0;
    end else if (o == stk_pkg::OP_NOP) begin
      push = 1'b0;
    end else if (o >= stk_pkg::OP_MULH && o <= stk_pkg::OP_MULHU) begin
      err_c = stk_pkg::ERR_NIMP;
    end else if (o >= stk_pkg::OP_RSVD) begin
      err_c = stk_pkg::ERR_BAD;
    end else begin
      push = 1'b1;
      if (o == stk_pkg::OP_ADD) r = a0_r + a1_r;
      else if (o == stk_pkg::OP_SUB) r = a0_r - a1_r;
      else if (o == stk_pkg::OP_RSUB) r = a1_r - a0_r;
      else if (o == stk_pkg::OP_NEG) r = 64'd0 - a0_r;
      else if (o == stk_pkg::OP_ADDW) r = stk_pkg::sext32(a0_r[31:0] + a1_r[31:0]);
      else if (o == stk_pkg::OP_SUBW) r = stk_pkg::sext32(a0_r[31:0] - a1_r[31:0]);
      else if (o == stk_pkg::OP_RSUBW) r = stk_pkg::sext32(a1_r[31:0] - a0_r[31:0]);
      else if (o == stk_pkg::OP_MUL) r = acc_r;
      else if (o == stk_pkg::OP_MULW) r = stk_pkg::sext32(acc_r[31:0]);
      else if (is_div) r = dres;
      else if (o < stk_pkg::OP_ADDW_A) r = a0_r + rv_r;
      else if (o < stk_pkg::OP_SLL) r = stk_pkg::sext32(a0_r[31:0] + rv_r[31:0]);
      else if (o == stk_pkg::OP_SLL) r = a0_r << a1_r[5:0];
      else if (o == stk_pkg::OP_SRL) r = a0_r >> a1_r[5:0];
      else if (o == stk_pkg::OP_SRA) r = $unsigned($signed(a0_r) >>> a1_r[5:0]);
      else if (o == stk_pkg::OP_SLLW) r = stk_pkg::sext32(a0_r[31:0] << a1_r[4:0]);
      else if (o == stk_pkg::OP_SRLW) r = stk_pkg::sext32(a0_r[31:0] >> a1_r[4:0]);
      else if (o == stk_pkg::OP_SRAW)
        r = stk_pkg::sext32($unsigned($signed(a0_r[31:0]) >>> a1_r[4:0]));
      else if (o == stk_pkg::OP_AND) r = a0_r & a1_r;
      else if (o == stk_pkg::OP_OR) r = a0_r | a1_r;
      else if (o == stk_pkg::OP_XOR) r = a0_r ^ a1_r;
      else if (o == stk_pkg::OP_NOT) r = ~a0_r;
      else if (o == stk_pkg::OP_SLT) r = {63'b0, $signed(a0_r) < $signed(a1_r)};
      else if (o == stk_pkg::OP_SLTU) r = {63'b0, a0_r < a1_r};
      else if (o == stk_pkg::OP_SEQ) r = {63'b0, a0_r == a1_r};
      else if (o < stk_pkg::OP_SLTU_A) r = {63'b0, $signed(a0_r) < $signed(rv_r)};
      else if (o < stk_pkg::OP_SEQ_A) r = {63'b0, a0_r < rv_r};
      else if (o < stk_pkg::OP_EXTB) r = {63'b0, a0_r == rv_r};
      else if (o == stk_pkg::OP_EXTB) r = {{56{a0_r[7]}}, a0_r[7:0]};
      else if (o == stk_pkg::OP_EXTUB) r = {56'b0, a0_r[7:0]};
      else if (o == stk_pkg::OP_EXTH) r = {{48{a0_r[15]}}, a0_r[15:0]};
      else if (o == stk_pkg::OP_EXTUH) r = {48'b0, a0_r[15:0]};
      else if (o == stk_pkg::OP_EXTW) r = stk_pkg::sext32(a0_r[31:0]);
      else if (o == stk_pkg::OP_EXTUW) r = {32'b0, a0_r[31:0]};
      else if (o < stk_pkg::OP_RD_R) r = rot_r[sidx];
      else if (o < stk_pkg::OP_WP_R) r = regs_r[ridx];
      else if (o < stk_pkg::OP_WR_R) begin
        ridx   = RW'(o - stk_pkg::OP_WP_R);
        reg_we = 1'b1;
        push   = 1'b0;
      end else if (o < stk_pkg::OP_RD_A) begin
        ridx   = RW'(o - stk_pkg::OP_WR_R);
        reg_we = 1'b1;
        r      = a0_r;
      end else if (o < stk_pkg::OP_SELZ_A) r = rv_r;
      else if (o < stk_pkg::OP_SELNZ_A) r = (rv_r != '0) ? a1_r : a0_r;
      else if (o < stk_pkg::OP_CONB) r = (rv_r != '0) ? a0_r : a1_r;
      else if (o < stk_pkg::OP_CONH) r = {{56{cr_r[7]}}, cr_r[7:0]};
      else if (o < stk_pkg::OP_CONW) r = {{48{cr_r[15]}}, cr_r[15:0]};
      else if (o < stk_pkg::OP_COND) r = stk_pkg::sext32(cr_r[31:0]);
      else r = cr_r;
    end
    // net stack motion: pops move down, a push moves up
    dsh = SW'(push) - SW'(na);
    for (int p = 0; p < STACK_DEPTH; p++) rot_nxt[p] = rot_r[SW'(p) + dsh];
    if (push) rot_nxt[0] = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACK_DEPTH; i++) rot_r[i] <= '0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
      mph_r <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= opcode;
        rv_r <= remote_value;
        cr_r <= const_raw;
      end
      if (cmd.op_start) begin
        a0_r   <= pa0;
        a1_r   <= pa1;
        acc_r  <= '0;
        mph_r  <= '0;
        quo_r  <= ua;
        rem_r  <= '0;
        ub_r   <= ub;
        negq_r <= div_sg && (dx[63] ^ dy[63]);
        negr_r <= div_sg && dx[63];
      end
      if (cmd.step) begin
        if (sts.needs_mul) begin
          p_r   <= 64'(mx * my);
          mph_r <= mph_r + 1'b1;
          if (mph_r == 2'd1) acc_r <= acc_r + p_r;
          else if (mph_r != 2'd0) acc_r <= acc_r + {p_r[31:0], 32'b0};
        end else begin
          rem_r <= ge ? 64'(trial - {1'b0, ub_r}) : trial[63:0];
          quo_r <= {quo_r[62:0], ge};
        end
      end
      if (cmd.commit) begin
        for (int i = 0; i < STACK_DEPTH; i++) rot_r[i] <= rot_nxt[i];
        if (reg_we) regs_r[ridx] <= a0_r;
        err_r <= err_c;
        top_r <= rot_nxt[0];
      end
    end
  end

  assign err_code  = err_r;
  assign top_value = top_r;

endmodule

// ===== design/stack_alu_execute.sv =====
// Sequence: decode, then the multi-step unit if any, then commit to the
//   output register; simple opcodes and divide by zero go straight to
//   commit, mul/mulw take four steps on one 32x32 multiplier and the
//   divide family a 64-step restoring divider; commit waits for a free
//   output register. One transaction is taken at a time, the next one
//   after commit; a done result may wait in the output register.
// Reset: rst_n synchronous, active low; clears stack, registers and control.
module stack_alu_execute #(
  parameter int STACK_DEPTH = stk_pkg::STACK_DEPTH_DEF,
  parameter int REG_COUNT   = stk_pkg::REG_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stk_in_if.sink    in_if,
  stk_out_if.source out_if
);

  stk_pkg::cmd_t cmd;
  stk_pkg::sts_t sts;

  // controller: decode, multi-step units, commit into output register
  stk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: rotated stack, register file, multiplier, divider
  stk_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .REG_COUNT   (REG_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (in_if.opcode),
    .remote_value (in_if.remote_value),
    .const_raw    (in_if.const_raw),
    .err_code     (out_if.err_code),
    .top_value    (out_if.top_value)
  );

  // one transaction in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second transaction accepted while busy");

  // commit never overwrites an untaken result
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_if.valid || out_if.ready))
    else $error("result overwritten");

  // a new result only follows a commit
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.commit))
    else $error("result without commit");

endmodule
